FILE: src/gb3_pkg.sv
package gb3_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 4;
	localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
	localparam int IDX_W        = $clog2(LINE_DEPTH);
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int CHAN_W       = $clog2(MAX_CHANNELS);
	localparam int CELLS        = 2 * MAX_CHANNELS;
	localparam int CELL_IW      = $clog2(CELLS);
	localparam int PIX_W        = 8;
	localparam int CW_W         = PIX_W + 2;
	localparam int SUM_W        = PIX_W + 4;
	localparam int LINE_W       = 2 * PIX_W;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam int OUTQ_DEPTH   = 4;
	localparam int OQ_AW        = $clog2(OUTQ_DEPTH);
	localparam int OQ_CW        = OQ_AW + 1;

	localparam logic [10:0] WIDTH_RST  = 11'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;
	localparam logic [2:0]  CHAN_RST   = 3'd1;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_DRAIN  = 1'b1;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] sample_value;
	} src_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             end_of_frame;
	} dst_t;

	typedef struct packed {
		logic shift;
		logic emit1;
		logic left_mask;
	} win_ctl_t;

endpackage

FILE: src/gb3_ram.sv
module gb3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/gb3_cell.sv
module gb3_cell import gb3_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [CW_W-1:0] d,
	output logic [CW_W-1:0] q
);

	logic [CW_W-1:0] wt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_q <= '0;
		end else if (en) begin
			wt_q <= d;
		end
	end

	assign q = wt_q;

endmodule

FILE: src/gb3_window.sv
module gb3_window import gb3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  win_ctl_t          ctl,
	input  logic [PIX_W-1:0]  top,
	input  logic [PIX_W-1:0]  mid,
	input  logic [PIX_W-1:0]  bot,
	input  logic [CHAN_W-1:0] chan_m1,
	output logic [PIX_W-1:0]  pixel
);

	logic [CW_W-1:0]  new_cw;
	logic [CW_W-1:0]  cell_q [CELLS];
	logic [CW_W-1:0]  tap_a;
	logic [CW_W-1:0]  tap_b;
	logic [CW_W-1:0]  left;
	logic [CW_W-1:0]  right;
	logic [SUM_W-1:0] sum;

	// column weight 1 2 1
	assign new_cw = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, bot};

	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		if (j == 0) begin : g_head
			gb3_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (ctl.shift),
				.d     (new_cw),
				.q     (cell_q[j])
			);
		end else begin : g_body
			gb3_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (ctl.shift),
				.d     (cell_q[j-1]),
				.q     (cell_q[j])
			);
		end
	end

	// same channel one and two pixels back
	assign tap_a = cell_q[CELL_IW'(chan_m1)];
	assign tap_b = cell_q[{chan_m1, 1'b1}];

	assign left  = ctl.left_mask ? '0 : tap_b;
	assign right = ctl.emit1 ? new_cw : '0;
	assign sum   = {2'b00, left} + {1'b0, tap_a, 1'b0} + {2'b00, right};
	assign pixel = sum[SUM_W-1:4];

endmodule

FILE: src/gaussian_blur_3x3_stream.sv
// 3x3 gaussian blur (1 2 1 / 2 4 2 / 1 2 1, sum >> 4) over a pixel stream, zero border.
// Request channel src: samples in raster order, channels of a pixel interleaved
// (action = 0). After the last sample of a frame, (image_width + 1) * channel_count
// drain requests (action = 1) flush the outputs still owed; the final one carries
// end_of_frame. A sample during the drain, or a drain request outside it, is taken
// and dropped.
// Result channel dst: blurred samples in raster order, pixel_out and end_of_frame.
// Throughput: one request per cycle while src is not stalled. Each kept request reads
// and rewrites one entry of the two line stores, held in one dual-port RAM, and shifts
// a chain of eight column cells. The request that completes a result is registered in
// stage 1; the result is then written to the result queue and offered on dst from its
// head. In the stream that request comes one row plus one pixel after the sample's own.
// dst has a four-entry queue; src stalls once the queue, counting a result still in
// flight, is full, so a stalled receiver fills the queue and then holds the sender.
// Reset: registers return to 640 x 480, one channel, counters cleared. A register
// write restarts the frame. Line stores need no clearing; the top rows are masked.
module gaussian_blur_3x3_stream import gb3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              src_valid,
	output logic              src_stall,
	input  src_t              src_data,
	output logic              dst_valid,
	input  logic              dst_stall,
	output dst_t              dst_data
);

	typedef struct packed {
		logic emit0;
		logic emit1;
		logic eof;
		logic top_ok;
		logic mid_ok;
		logic c_is1;
	} s1_ctl_t;

	logic [10:0] width_q;
	logic [11:0] height_q;
	logic [2:0]  chans_q;
	logic [10:0] width_wr;
	logic [11:0] height_wr;
	logic [2:0]  chans_wr;
	logic [1:0]  reg_sel;
	logic        cfg_wr;
	logic        cfg_restart;

	logic [11:0]       row_q;
	logic [COL_W-1:0]  col_q;
	logic [CHAN_W-1:0] chan_q;
	logic [IDX_W-1:0]  idx_q;
	logic [12:0]       pend_q;
	logic [14:0]       pend_load;

	logic        take;
	logic        drain;
	logic        live;
	logic [12:0] r;
	logic [12:0] hp1;
	logic [12:0] hp2;
	logic        chan_last;
	logic        col_last;
	logic        frame_done;
	s1_ctl_t     ctl_s0;

	logic             valid_s1;
	s1_ctl_t          ctl_s1;
	logic [PIX_W-1:0] bot_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	logic [LINE_W-1:0] ram_rd;
	logic [LINE_W-1:0] line_old;
	logic [LINE_W-1:0] wr_data;
	logic [PIX_W-1:0]  top;
	logic [PIX_W-1:0]  mid;
	win_ctl_t          win_ctl;
	logic [PIX_W-1:0]  pixel;
	logic [2:0]        chan_m1;

	dst_t             oq_q [OUTQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             push;
	logic             pop;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg_restart = cfg_wr && (reg_sel == REG_IMAGE_WIDTH
		|| reg_sel == REG_IMAGE_HEIGHT || reg_sel == REG_CHANNEL_COUNT);

	always_comb begin
		width_wr  = pwdata[10:0];
		height_wr = pwdata[11:0];
		chans_wr  = pwdata[2:0];
		if (width_wr == '0) begin
			width_wr = 11'd1;
		end else if (width_wr > 11'(MAX_WIDTH)) begin
			width_wr = 11'(MAX_WIDTH);
		end
		if (height_wr == '0) begin
			height_wr = 12'd1;
		end
		if (chans_wr == '0) begin
			chans_wr = 3'd1;
		end else if (chans_wr > 3'(MAX_CHANNELS)) begin
			chans_wr = 3'(MAX_CHANNELS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			chans_q  <= CHAN_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:   width_q  <= width_wr;
				REG_IMAGE_HEIGHT:  height_q <= height_wr;
				REG_CHANNEL_COUNT: chans_q  <= chans_wr;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:   prdata = {21'd0, width_q};
			REG_IMAGE_HEIGHT:  prdata = {20'd0, height_q};
			REG_CHANNEL_COUNT: prdata = {29'd0, chans_q};
			default:           prdata = '0;
		endcase
	end

	// request decode
	assign take  = src_valid && !src_stall;
	assign drain = src_data.action == ACT_DRAIN;
	assign live  = take && (drain ? pend_q != '0 : pend_q == '0);

	assign r   = drain ? {1'b0, height_q} + {1'b0, row_q} : {1'b0, row_q};
	assign hp1 = {1'b0, height_q} + 13'd1;
	assign hp2 = {1'b0, height_q} + 13'd2;
	assign chan_m1   = chans_q - 3'd1;
	assign chan_last = {1'b0, chan_q} == chan_m1;
	assign col_last  = {1'b0, col_q} + 11'd1 >= width_q;
	assign frame_done = chan_last && col_last && ({1'b0, row_q} + 13'd1 >= {1'b0, height_q});
	assign pend_load  = ({1'b0, width_q} + 12'd1) * chans_q;

	always_comb begin
		ctl_s0.top_ok = r >= 13'd2;
		ctl_s0.mid_ok = r >= 13'd1;
		ctl_s0.emit0  = col_q == '0 && r >= 13'd2 && r < hp2;
		ctl_s0.emit1  = col_q != '0 && r >= 13'd1 && r < hp1;
		ctl_s0.eof    = ctl_s0.emit0 && r == hp1 && chan_last;
		ctl_s0.c_is1  = col_q == COL_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
			idx_q  <= '0;
			pend_q <= '0;
		end else if (cfg_restart) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
			idx_q  <= '0;
			pend_q <= '0;
		end else if (live) begin
			if (chan_last) begin
				chan_q <= '0;
				if (col_last) begin
					col_q <= '0;
					idx_q <= '0;
					row_q <= row_q + 12'd1;
				end else begin
					col_q <= col_q + COL_W'(1);
					idx_q <= idx_q + IDX_W'(1);
				end
			end else begin
				chan_q <= chan_q + CHAN_W'(1);
				idx_q  <= idx_q + IDX_W'(1);
			end
			if (!drain && frame_done) begin
				row_q  <= '0;
				col_q  <= '0;
				chan_q <= '0;
				idx_q  <= '0;
				pend_q <= pend_load[12:0];
			end
			if (drain) begin
				pend_q <= pend_q - 13'd1;
				if (pend_q == 13'd1) begin
					row_q  <= '0;
					col_q  <= '0;
					chan_q <= '0;
					idx_q  <= '0;
				end
			end
		end
	end

	// stage 1: line store data back, window shift, sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= live;
		end
	end

	always_ff @(posedge clk) begin
		if (live) begin
			ctl_s1      <= ctl_s0;
			bot_s1      <= drain ? '0 : src_data.sample_value;
			idx_s1      <= idx_q;
			fwd_s1      <= valid_s1 && idx_s1 == idx_q;
			fwd_data_s1 <= wr_data;
		end
	end

	gb3_ram #(
		.WIDTH(LINE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(idx_s1),
		.wdata(wr_data),
		.raddr(idx_q),
		.rdata(ram_rd)
	);

	// upper byte: row above, lower byte: two rows above
	assign line_old = fwd_s1 ? fwd_data_s1 : ram_rd;
	assign wr_data  = {bot_s1, line_old[LINE_W-1:PIX_W]};
	assign top = ctl_s1.top_ok ? line_old[PIX_W-1:0] : '0;
	assign mid = ctl_s1.mid_ok ? line_old[LINE_W-1:PIX_W] : '0;

	always_comb begin
		win_ctl.shift     = valid_s1;
		win_ctl.emit1     = ctl_s1.emit1;
		win_ctl.left_mask = ctl_s1.emit1 ? ctl_s1.c_is1 : width_q == 11'd1;
	end

	gb3_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.top    (top),
		.mid    (mid),
		.bot    (bot_s1),
		.chan_m1(chan_m1[CHAN_W-1:0]),
		.pixel  (pixel)
	);

	// result queue
	assign push      = valid_s1 && (ctl_s1.emit0 || ctl_s1.emit1);
	assign pop       = dst_valid && !dst_stall;
	assign dst_valid = cnt_q != '0;
	assign dst_data  = oq_q[rd_ptr_q];
	assign src_stall = cnt_q + OQ_CW'(push) >= OQ_CW'(OUTQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			oq_q[wr_ptr_q] <= '{pixel_out: pixel, end_of_frame: ctl_s1.eof};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			cnt_q <= cnt_q + OQ_CW'(push) - OQ_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == OQ_CW'(OUTQ_DEPTH)))
		else $error("result queue overflow");

	a_eof_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctl_s1.eof |-> pend_q == '0)
		else $error("end of frame not on the last drain request");

	a_sample_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		take && src_data.action == ACT_SAMPLE && pend_q != '0 && !cfg_restart |=> !valid_s1)
		else $error("sample taken during drain");

	a_fwd_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> chans_q == 3'd1)
		else $error("line store bypass with several channels");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import gb3_pkg::*; ();

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          LATENCY_PAD = 8;
	localparam int          HOLD_LEN    = 300;
	localparam logic [1:0]  REG_SPARE   = 2'd3;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              src_valid = 1'b0;
	logic              src_stall;
	src_t              src_data  = '0;
	logic              dst_valid;
	logic              dst_stall = 1'b0;
	dst_t              dst_data;

	gaussian_blur_3x3_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	// blur predictor state
	bit [PIX_W-1:0] line_up  [LINE_DEPTH];
	bit [PIX_W-1:0] line_up2 [LINE_DEPTH];
	bit [PIX_W-1:0] win [MAX_CHANNELS][3][3];
	int unsigned    cfg_w = 640;
	int unsigned    cfg_h = 480;
	int unsigned    cfg_c = 1;
	int unsigned    row, col, chan, owed;
	dst_t           pix_q [$];

	int unsigned    err_cnt;
	int unsigned    acc_cnt;
	int unsigned    real_items;
	int unsigned    cyc;
	int             src_idle_pct;
	int             dst_stall_pct;
	logic           hold_on = 1'b0;
	event           hold_ev;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cyc, pix_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		if (err_cnt < 100)
			$display("mismatch @%0t: %s", $realtime, what);
		err_cnt++;
	endtask

	function automatic int unsigned col_wt(input int unsigned ch, input int unsigned k);
		return win[ch][k][0] + 2 * win[ch][k][1] + win[ch][k][2];
	endfunction

	function automatic logic [PIX_W-1:0] blur_of(input int unsigned ch, input int unsigned ci,
			input bit use_l, input bit use_r);
		int unsigned s;
		s = 2 * col_wt(ch, ci);
		if (use_l)
			s += col_wt(ch, ci - 1);
		if (use_r)
			s += col_wt(ch, ci + 1);
		return PIX_W'(s >> 4);
	endfunction

	function automatic void restart_frame();
		row  = 0;
		col  = 0;
		chan = 0;
		owed = 0;
	endfunction

	function automatic void cfg_store(input logic [1:0] idx, input logic [31:0] v);
		int unsigned x;
		case (idx)
			REG_IMAGE_WIDTH: begin
				x = v[10:0];
				if (x == 0)
					x = 1;
				if (x > MAX_WIDTH)
					x = MAX_WIDTH;
				cfg_w = x;
			end
			REG_IMAGE_HEIGHT: begin
				x = v[11:0];
				if (x == 0)
					x = 1;
				cfg_h = x;
			end
			REG_CHANNEL_COUNT: begin
				x = v[2:0];
				if (x == 0)
					x = 1;
				if (x > MAX_CHANNELS)
					x = MAX_CHANNELS;
				cfg_c = x;
			end
			default: return;
		endcase
		restart_frame();
	endfunction

	function automatic void blur_predict(input src_t rq);
		bit             drn;
		bit             got;
		int unsigned    r, c, ch, idx;
		bit [PIX_W-1:0] t, m, b;
		dst_t           o;
		got = 1'b0;
		o   = '0;
		if (rq.action == ACT_SAMPLE) begin
			if (owed != 0)
				return;
			drn = 1'b0;
			r   = row;
		end else begin
			if (owed == 0)
				return;
			drn = 1'b1;
			r   = cfg_h + row;
		end
		c  = col;
		ch = chan;
		// last pixel of the row two back
		if (c == 0 && r >= 2 && r - 2 < cfg_h) begin
			o.pixel_out    = blur_of(ch, 2, cfg_w != 1, 1'b0);
			o.end_of_frame = (r - 2 == cfg_h - 1) && (ch == cfg_c - 1);
			got = 1'b1;
		end
		idx = c * cfg_c + ch;
		t = (r >= 2) ? line_up2[idx] : '0;
		m = (r >= 1) ? line_up[idx] : '0;
		b = drn ? '0 : rq.sample_value;
		line_up2[idx] = line_up[idx];
		line_up[idx]  = b;
		for (int k = 0; k < 2; k++)
			for (int j = 0; j < 3; j++)
				win[ch][k][j] = win[ch][k + 1][j];
		win[ch][2][0] = t;
		win[ch][2][1] = m;
		win[ch][2][2] = b;
		if (c >= 1 && r >= 1 && r - 1 < cfg_h) begin
			o.pixel_out    = blur_of(ch, 1, c != 1, 1'b1);
			o.end_of_frame = 1'b0;
			got = 1'b1;
		end
		ch++;
		if (ch >= cfg_c) begin
			ch = 0;
			c++;
			if (c >= cfg_w) begin
				c = 0;
				row++;
			end
		end
		chan = ch;
		col  = c;
		if (!drn) begin
			if (row >= cfg_h) begin
				restart_frame();
				owed = (cfg_w + 1) * cfg_c;
			end
		end else begin
			owed--;
			if (owed == 0)
				restart_frame();
		end
		if (got)
			pix_q.push_back(o);
	endfunction

	always @(posedge clk) begin
		dst_t want;
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				acc_cnt++;
				blur_predict(src_data);
			end
			if (dst_valid && !dst_stall) begin
				if (pix_q.size() == 0) begin
					flag_mismatch($sformatf("result %0h with nothing expected", dst_data));
				end else begin
					want = pix_q.pop_front();
					if (dst_data.pixel_out !== want.pixel_out)
						flag_mismatch($sformatf("pixel_out %0d, expected %0d",
							dst_data.pixel_out, want.pixel_out));
					if (dst_data.end_of_frame !== want.end_of_frame)
						flag_mismatch($sformatf("end_of_frame %0b, expected %0b",
							dst_data.end_of_frame, want.end_of_frame));
				end
			end
		end
	end

	always @(posedge clk)
		dst_stall <= hold_on || ($urandom_range(99) < dst_stall_pct);

	initial begin
		forever begin
			@(hold_ev);
			hold_on <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	task automatic send_req(input logic act, input logic [PIX_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= src_t'{act, v};
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
	endtask

	// stop offering, wait for every result, then let the pipeline run dry
	task automatic settle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pix_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_store(idx, v);
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [1:0] idx, input int unsigned want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			flag_mismatch($sformatf("register %0d reads %0d, expected %0d",
				idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_regs();
		read_reg(REG_IMAGE_WIDTH, cfg_w);
		read_reg(REG_IMAGE_HEIGHT, cfg_h);
		read_reg(REG_CHANNEL_COUNT, cfg_c);
	endtask

	function automatic logic [31:0] with_junk(input logic [31:0] v, input int bits);
		if ($urandom_range(3) == 0)
			return (32'($urandom) << bits) | v;
		return v;
	endfunction

	// one frame at the current setting; noise requests are ones the block drops
	task automatic send_frame(input int noise_pct, input int stop_at, input int pause_at);
		int n_smp;
		int n_all;
		n_smp = cfg_w * cfg_h * cfg_c;
		n_all = n_smp + (cfg_w + 1) * cfg_c;
		for (int k = 0; k < n_all; k++) begin
			if (k == stop_at)
				break;
			if (k == pause_at)
				settle();
			if ($urandom_range(99) < noise_pct)
				send_req(k < n_smp ? ACT_DRAIN : ACT_SAMPLE, PIX_W'($urandom));
			send_req(k < n_smp ? ACT_SAMPLE : ACT_DRAIN, PIX_W'($urandom));
			real_items++;
		end
	endtask

	task automatic test_reset_values();
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		check_regs();
		for (int k = 0; k < 660; k++)
			send_req(ACT_SAMPLE, PIX_W'($urandom));
		settle();
	endtask

	task automatic test_corner_frames();
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		write_reg(REG_IMAGE_WIDTH, 32'd2);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		write_reg(REG_CHANNEL_COUNT, 32'd1);
		send_req(ACT_DRAIN, 8'hA5);
		send_req(ACT_SAMPLE, 8'hFF);
		send_req(ACT_SAMPLE, 8'h00);
		send_req(ACT_SAMPLE, 8'h00);
		send_req(ACT_SAMPLE, 8'hFF);
		send_req(ACT_DRAIN, 8'h00);
		send_req(ACT_SAMPLE, 8'h5A);
		send_req(ACT_DRAIN, 8'hFF);
		send_req(ACT_DRAIN, 8'h00);
		settle();
		// single pixel frame
		write_reg(REG_IMAGE_WIDTH, 32'd1);
		write_reg(REG_IMAGE_HEIGHT, 32'd1);
		send_req(ACT_SAMPLE, 8'hFF);
		send_req(ACT_DRAIN, 8'h00);
		send_req(ACT_DRAIN, 8'h00);
		settle();
		// a write to the spare address must not restart the frame
		write_reg(REG_CHANNEL_COUNT, 32'd2);
		write_reg(REG_IMAGE_WIDTH, 32'd2);
		send_req(ACT_SAMPLE, 8'hFF);
		send_req(ACT_SAMPLE, 8'hFF);
		settle();
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_req(ACT_SAMPLE, 8'h00);
		send_req(ACT_SAMPLE, 8'hFF);
		repeat (6) send_req(ACT_DRAIN, PIX_W'($urandom));
		settle();
	endtask

	task automatic test_register_extremes();
		src_idle_pct  = 35;
		dst_stall_pct = 35;
		write_reg(REG_IMAGE_WIDTH, 32'h0000_07FF);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		write_reg(REG_CHANNEL_COUNT, 32'd0);
		check_regs();
		send_frame(5, 60, -1);
		settle();
		write_reg(REG_IMAGE_WIDTH, 32'd0);
		write_reg(REG_IMAGE_HEIGHT, 32'h0000_0FFF);
		write_reg(REG_CHANNEL_COUNT, 32'd1);
		check_regs();
		send_frame(5, 60, -1);
		settle();
		write_reg(REG_CHANNEL_COUNT, 32'd7);
		write_reg(REG_IMAGE_WIDTH, 32'd3);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		check_regs();
		send_frame(5, -1, -1);
		settle();
	endtask

	task automatic test_backpressure();
		int unsigned mark;
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		write_reg(REG_IMAGE_WIDTH, 32'd6);
		write_reg(REG_IMAGE_HEIGHT, 32'd5);
		write_reg(REG_CHANNEL_COUNT, 32'd2);
		mark = acc_cnt;
		fork
			send_frame(0, -1, 40);
			begin
				wait (acc_cnt >= mark + 10);
				-> hold_ev;
			end
		join
		settle();
	endtask

	task automatic test_random_frames();
		int unsigned goal;
		int          total;
		int          stop;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
				1: begin src_idle_pct = 63; dst_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  dst_stall_pct = 63; end
				default: begin src_idle_pct = 35; dst_stall_pct = 35; end
			endcase
			goal = real_items + 90;
			while (real_items < goal) begin
				settle();
				write_reg(REG_IMAGE_WIDTH, with_junk($urandom_range(0, 9), 11));
				write_reg(REG_IMAGE_HEIGHT, with_junk($urandom_range(0, 6), 12));
				write_reg(REG_CHANNEL_COUNT, with_junk($urandom_range(0, 7), 3));
				total = cfg_w * cfg_h * cfg_c + (cfg_w + 1) * cfg_c;
				stop  = ($urandom_range(4) == 0) ? int'($urandom_range(1, total - 1)) : -1;
				send_frame(10, stop, -1);
			end
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_corner_frames();
		test_register_extremes();
		test_backpressure();
		test_random_frames();
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
